[src/zrle_pkg.sv]
// Shared types and constants for the zero-run escape encoder.
// No dependencies; imported by every other file of the block.
package zrle_pkg;

    localparam logic [7:0]  ESC_BYTE  = 8'hFF;
    localparam logic [7:0]  ZERO_BYTE = 8'h00;
    localparam logic [23:0] RUN_LIMIT = 24'hFEFFFF;
    localparam logic [23:0] RUN_START = 24'd2;

    // Default depth of the job queue between front and back end.
    localparam int JOB_DEPTH = 4;

    // Result steps of one job, emitted lowest bit first.
    localparam int STEP_ESC       = 0;
    localparam int STEP_CNT_HI    = 1;
    localparam int STEP_CNT_MID   = 2;
    localparam int STEP_CNT_LO    = 3;
    localparam int STEP_PRE_ZERO  = 4;
    localparam int STEP_BYTE      = 5;
    localparam int STEP_DUP       = 6;
    localparam int STEP_TAIL_ZERO = 7;
    localparam int STEP_TAIL_FILL = 8;
    localparam int NUM_STEPS      = 9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [23:0] zero_fill;
        logic        run_too_long;
        logic        last;
    } t_out;

    // One classified input item: which beats to emit and their data.
    typedef struct packed {
        logic [NUM_STEPS-1:0] steps;
        logic [7:0]           data;
        logic [23:0]          count;
        logic                 flag;
    } t_job;

endpackage

[src/zero_run_escape_encoder_unit.sv]
// Zero-run escape encoder, top level: front end, job queue and beat sequencer.
// Depends on zrle_pkg, zrle_front, zrle_fifo and zrle_back.
//
// Usage: push one raw byte per beat (with end_of_stream on the final byte of a
// stream); pop encoded beats from the result side. The front end classifies each
// byte in the cycle it is accepted and updates the run state, so the input side
// takes one byte per clock as long as the job queue (JOB_DEPTH entries) has room;
// full only reflects that queue. Each byte yields zero to six result beats, which
// the back end sends at one beat per clock through its output register while
// results are popped, so the sustained rate is one item per cycle for literal
// traffic and is bounded by the beat count for escaped bytes and closed runs. A job
// passes the queue and the step register before its first beat is registered. Bytes
// that only hold a zero or extend a run produce no beat. After an end_of_stream
// byte the run state is back to reset and the next byte starts a fresh stream.
module zero_run_escape_encoder_unit #(
    parameter int JOB_DEPTH = zrle_pkg::JOB_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  zrle_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output zrle_pkg::t_out o_out
);
    import zrle_pkg::*;

    logic q_full, q_push, q_valid, q_rd;
    t_job front_job, q_job;

    // Front: run/held-zero tracking, one job per producing byte.
    zrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_job    (front_job)
    );

    // Queue of classified jobs; lets the input keep going while beats drain.
    zrle_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_job   (front_job),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back: walks the job's steps, one result beat per clock while results are popped.
    zrle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

[src/zrle_front.sv]
// Front end: accepts raw bytes, tracks zero-run state, emits one job per producing byte.
// Depends on zrle_pkg.
module zrle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  zrle_pkg::t_in i_in,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_q_push,
    output zrle_pkg::t_job o_job
);
    import zrle_pkg::*;

    logic        r_in_run, n_in_run;
    logic        r_held,   n_held;
    logic [23:0] r_count,  n_count;
    logic        r_sat,    n_sat;
    logic        accept;
    t_job        job;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        n_in_run  = r_in_run;
        n_held    = r_held;
        n_count   = r_count;
        n_sat     = r_sat;
        job       = '0;
        job.data  = i_in.in_byte;

        if (r_in_run) begin
            if (i_in.in_byte == ZERO_BYTE) begin
                if (r_count >= RUN_LIMIT) begin
                    n_count = RUN_LIMIT;
                    n_sat   = 1'b1;
                end else begin
                    n_count = r_count + 24'd1;
                end
            end else begin
                // run closes: FF, three count bytes, then the byte (twice if it is FF)
                job.steps[STEP_ESC]     = 1'b1;
                job.steps[STEP_CNT_HI]  = 1'b1;
                job.steps[STEP_CNT_MID] = 1'b1;
                job.steps[STEP_CNT_LO]  = 1'b1;
                job.steps[STEP_BYTE]    = 1'b1;
                job.steps[STEP_DUP]     = (i_in.in_byte == ESC_BYTE);
                job.count               = r_count;
                job.flag                = r_sat;
                n_in_run = 1'b0;
                n_count  = '0;
                n_sat    = 1'b0;
            end
        end else if (i_in.in_byte == ZERO_BYTE) begin
            if (r_held) begin
                n_held   = 1'b0;
                n_in_run = 1'b1;
                n_count  = RUN_START;
                n_sat    = 1'b0;
            end else begin
                n_held = 1'b1;
            end
        end else begin
            job.steps[STEP_PRE_ZERO] = r_held;
            job.steps[STEP_BYTE]     = 1'b1;
            job.steps[STEP_DUP]      = (i_in.in_byte == ESC_BYTE);
            n_held = 1'b0;
        end

        if (i_in.end_of_stream) begin
            if (n_held) begin
                job.steps[STEP_TAIL_ZERO] = 1'b1;
            end else if (n_in_run) begin
                job.steps[STEP_TAIL_FILL] = 1'b1;
                job.count                 = n_count;
                job.flag                  = n_sat;
            end
            n_in_run = 1'b0;
            n_held   = 1'b0;
            n_count  = '0;
            n_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_held   <= 1'b0;
            r_count  <= '0;
            r_sat    <= 1'b0;
        end else if (accept) begin
            r_in_run <= n_in_run;
            r_held   <= n_held;
            r_count  <= n_count;
            r_sat    <= n_sat;
        end
    end

    // items that only hold a zero or extend a run make no job
    assign o_q_push = accept && (job.steps != '0);
    assign o_job    = job;

endmodule

[src/zrle_fifo.sv]
// Short job queue decoupling the front end from the beat sequencer.
// Depends on zrle_pkg.
module zrle_fifo #(
    parameter int DEPTH = zrle_pkg::JOB_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  zrle_pkg::t_job i_job,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_valid,
    output zrle_pkg::t_job o_job
);
    import zrle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/zrle_back.sv]
// Back end: expands one job into result beats, one per cycle while popped, into an output register.
// Depends on zrle_pkg.
module zrle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  zrle_pkg::t_job i_job,
    output logic           o_job_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output zrle_pkg::t_out o_out
);
    import zrle_pkg::*;

    t_job                 r_job;
    logic [NUM_STEPS-1:0] r_steps, n_steps;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [NUM_STEPS-1:0] sel, rest;
    logic                 advance, emit, load;
    t_out                 beat;

    assign advance = !r_out_valid || i_pop;
    assign sel     = r_steps & (~r_steps + 1'b1);   // lowest pending step
    assign rest    = r_steps & ~sel;
    assign emit    = advance && (r_steps != '0);
    assign load    = i_job_valid && ((r_steps == '0) || (emit && (rest == '0)));
    assign o_job_rd = load;

    always_comb begin
        beat              = '0;
        beat.byte_valid   = 1'b1;
        beat.run_too_long = r_job.flag;
        beat.last         = (rest == '0);
        priority if (r_steps[STEP_ESC]) begin
            beat.out_byte = ESC_BYTE;
        end else if (r_steps[STEP_CNT_HI]) begin
            beat.out_byte = r_job.count[23:16];
        end else if (r_steps[STEP_CNT_MID]) begin
            beat.out_byte = r_job.count[15:8];
        end else if (r_steps[STEP_CNT_LO]) begin
            beat.out_byte = r_job.count[7:0];
        end else if (r_steps[STEP_PRE_ZERO]) begin
            beat.out_byte     = ZERO_BYTE;
            beat.run_too_long = 1'b0;
        end else if (r_steps[STEP_BYTE] || r_steps[STEP_DUP]) begin
            beat.out_byte = r_job.data;
        end else if (r_steps[STEP_TAIL_ZERO]) begin
            beat.out_byte     = ZERO_BYTE;
            beat.run_too_long = 1'b0;
        end else begin
            // tail fill: no byte, report the open run length
            beat.byte_valid = 1'b0;
            beat.zero_fill  = r_job.count;
        end
    end

    always_comb begin
        if (load) begin
            n_steps = i_job.steps;
        end else if (emit) begin
            n_steps = rest;
        end else begin
            n_steps = r_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_steps <= n_steps;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

[src/zrle_checker.sv]
// Port-level checks for zero_run_escape_encoder_unit, bound to the top level.
// Depends on zrle_pkg and zero_run_escape_encoder_unit.
module zrle_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input zrle_pkg::t_out o_out
);
    import zrle_pkg::*;

    // reset leaves both sides open and nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

    // a held result stays put until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("stalled result changed");

    // a tail fill carries no byte and always closes its item
    a_fill_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.byte_valid) |-> (o_out.out_byte == ZERO_BYTE && o_out.last))
        else $error("malformed tail fill beat");

    // byte beats report no fill
    a_byte_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.byte_valid) |-> (o_out.zero_fill == '0))
        else $error("fill count on a byte beat");

    // fill never exceeds the counter's limit
    a_fill_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.zero_fill <= RUN_LIMIT))
        else $error("fill count above limit");

endmodule

bind zero_run_escape_encoder_unit zrle_checker u_zrle_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

[test/tb_zero_run_escape_encoder_unit.sv]
// Testbench for zero_run_escape_encoder_unit: directed and random byte streams,
// checked beat by beat against an encoder model kept inside the bench.
// Depends on zrle_pkg and the encoder RTL; reads no files.
module tb_zero_run_escape_encoder_unit;
    import zrle_pkg::*;

    // ~200 bytes; even with the longest idle gaps and every beat stalled, a run stays well inside the limit.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_ITEMS  = 80;
    localparam int QUIET_ITEMS   = 30;      // tail of the random part runs without idling
    localparam int SETTLE_CYCLES = 16;      // room for stray beats after the owed queue drains
    localparam int LONG_HOLD     = 300;     // output stall that backs the queue up

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_in;
    logic empty;
    logic pop;
    t_out o_out;

    zero_run_escape_encoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model: run state plus the queue of beats still owed by the DUT
    // ------------------------------------------------------------------
    logic        enc_in_run;
    logic        enc_held_zero;
    logic [23:0] enc_run_len;
    logic        enc_run_sat;
    t_out        owed_beats[$];

    int n_err     = 0;
    int n_bytes   = 0;
    int n_beats   = 0;
    int n_streams = 0;
    int n_runs    = 0;
    int n_cycles  = 0;

    // Idle controls shared between the driver processes.
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold = 0;

    function automatic void clear_encoder();
        enc_in_run    = 1'b0;
        enc_held_zero = 1'b0;
        enc_run_len   = '0;
        enc_run_sat   = 1'b0;
    endfunction

    function automatic void owe_beat(logic [7:0] b, logic valid, logic [23:0] fill,
                                     logic flag);
        t_out r;
        r.out_byte     = b;
        r.byte_valid   = valid;
        r.zero_fill    = fill;
        r.run_too_long = flag;
        r.last         = 1'b0;
        owed_beats.push_back(r);
    endfunction

    // Encode one accepted byte and append the beats it must produce.
    function automatic void encode_byte(t_in beat);
        int   queued;
        t_out tail;
        queued = owed_beats.size();
        if (enc_in_run) begin
            if (beat.in_byte == ZERO_BYTE) begin
                // counter sticks at its limit; further zeros only set the flag
                if (enc_run_len >= RUN_LIMIT) begin
                    enc_run_len = RUN_LIMIT;
                    enc_run_sat = 1'b1;
                end else begin
                    enc_run_len++;
                end
            end else begin
                // run closed by a non-zero byte: FF, count MSB first, the byte (twice if FF)
                owe_beat(ESC_BYTE, 1'b1, '0, enc_run_sat);
                owe_beat(enc_run_len[23:16], 1'b1, '0, enc_run_sat);
                owe_beat(enc_run_len[15:8], 1'b1, '0, enc_run_sat);
                owe_beat(enc_run_len[7:0], 1'b1, '0, enc_run_sat);
                owe_beat(beat.in_byte, 1'b1, '0, enc_run_sat);
                if (beat.in_byte == ESC_BYTE)
                    owe_beat(beat.in_byte, 1'b1, '0, enc_run_sat);
                clear_encoder();
                n_runs++;
            end
        end else if (beat.in_byte == ZERO_BYTE) begin
            if (enc_held_zero) begin
                enc_held_zero = 1'b0;
                enc_in_run    = 1'b1;
                enc_run_len   = RUN_START;
                enc_run_sat   = 1'b0;
            end else begin
                enc_held_zero = 1'b1;
            end
        end else begin
            // lone held zero goes out as a plain literal ahead of this byte
            if (enc_held_zero) begin
                owe_beat(ZERO_BYTE, 1'b1, '0, 1'b0);
                enc_held_zero = 1'b0;
            end
            owe_beat(beat.in_byte, 1'b1, '0, 1'b0);
            if (beat.in_byte == ESC_BYTE)
                owe_beat(beat.in_byte, 1'b1, '0, 1'b0);
        end

        if (beat.end_of_stream) begin
            if (enc_held_zero)
                owe_beat(ZERO_BYTE, 1'b1, '0, 1'b0);
            else if (enc_in_run)
                owe_beat(ZERO_BYTE, 1'b0, enc_run_len, enc_run_sat);
            clear_encoder();
            n_streams++;
        end

        // final beat of this byte carries last
        if (owed_beats.size() > queued) begin
            tail      = owed_beats.pop_back();
            tail.last = 1'b1;
            owed_beats.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: pop driver and beat checker
    // ------------------------------------------------------------------
    // Pop changes on the falling edge. A long hold, when armed, is counted
    // down here; otherwise, while sink_idle is set, random stall bursts are drawn.
    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endfunction

    // Sampled at the rising edge, before the DUT's registers move.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && pop && !empty) begin
            n_beats++;
            if (owed_beats.size() == 0) begin
                $error("unexpected beat: out_byte 0x%0h byte_valid %0b last %0b",
                       o_out.out_byte, o_out.byte_valid, o_out.last);
                n_err++;
            end else begin
                want = owed_beats.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(o_out.out_byte));
                check_field("byte_valid", 32'(want.byte_valid), 32'(o_out.byte_valid));
                check_field("zero_fill", 32'(want.zero_fill), 32'(o_out.zero_fill));
                check_field("run_too_long", 32'(want.run_too_long),
                            32'(o_out.run_too_long));
                check_field("last", 32'(want.last), 32'(o_out.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Entered and left on a falling edge. Push stays high from one byte to
    // the next unless an idle burst is drawn, so it is never dropped and
    // raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in beat;
        int  gap;
        beat.in_byte       = b;
        beat.end_of_stream = eos;
        gap = 0;
        if (src_idle && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encode_byte(beat);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_zeros(input int count);
        repeat (count) send_byte(ZERO_BYTE, 1'b0);
    endtask

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // Sender goes quiet until every owed beat has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (owed_beats.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Plain bytes at both ends of the range, and the FF escape.
    task automatic test_literals();
        send_byte(8'h01, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Held zero, shortest run, a run closed by FF, and every end-of-stream flavor.
    task automatic test_zero_cases();
        send_byte(ZERO_BYTE, 1'b0);         // held zero flushed as literal
        send_byte(8'h05, 1'b0);
        send_zeros(2);                      // run of two closed by FF -> doubled
        send_byte(ESC_BYTE, 1'b0);
        send_zeros(3);
        send_byte(8'h01, 1'b0);
        send_byte(ZERO_BYTE, 1'b1);         // held zero at end of stream
        send_byte(ZERO_BYTE, 1'b0);         // run opened by the final byte
        send_byte(ZERO_BYTE, 1'b1);
        send_zeros(2);                      // run extended by the final byte
        send_byte(ZERO_BYTE, 1'b1);
        send_byte(ZERO_BYTE, 1'b0);         // held zero, then FF with end mark
        send_byte(ESC_BYTE, 1'b1);
        send_zeros(2);                      // run closed by the final byte: no fill
        send_byte(8'hAA, 1'b1);
        send_byte(8'hFE, 1'b1);
    endtask

    // Longer runs closed by a literal and by FF, then a run left open as a tail
    // fill. Counts stay in the low count byte; the upper count bytes and the
    // counter limit take far more zeros than this run sends.
    task automatic test_long_runs();
        send_zeros(20);
        send_byte(8'h12, 1'b0);
        send_zeros(12);
        send_byte(ESC_BYTE, 1'b0);
        send_zeros(6);
        send_byte(ZERO_BYTE, 1'b1);
    endtask

    // Output stalled for a long stretch while bytes keep coming: queue fills,
    // full must hold the sender off without losing a beat.
    task automatic test_backpressure();
        sink_hold = LONG_HOLD;
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                send_byte(ESC_BYTE, 1'b0);
            else
                send_byte(nonzero_byte(), 1'b0);
        end
        send_zeros(5);
        send_byte(8'h3C, 1'b1);
    endtask

    // Sender pauses with a run open and nothing owed, then resumes mid-run.
    task automatic test_drain_pause();
        wait_drained();
        send_zeros(4);
        wait_drained();
        send_zeros(2);
        send_byte(8'h33, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed material (literals, held zeros, runs closed by
    // random bytes, stream ends) with some raw noise mixed in.
    task automatic test_random_streams();
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
                src_idle  = $urandom_range(0, 2) != 0;
                sink_idle = $urandom_range(0, 2) != 0;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    send_byte(8'($urandom_range(1, 254)), $urandom_range(0, 15) == 0);
                    sent += 1;
                end
                3: begin
                    send_byte(ESC_BYTE, $urandom_range(0, 15) == 0);
                    sent += 1;
                end
                4: begin
                    send_byte(ZERO_BYTE, 1'b0);
                    send_byte(nonzero_byte(), $urandom_range(0, 7) == 0);
                    sent += 2;
                end
                5, 6: begin
                    len = $urandom_range(2, 24);
                    send_zeros(len);
                    if ($urandom_range(0, 4) == 0)
                        send_byte(ZERO_BYTE, 1'b1);     // run reported as fill
                    else
                        send_byte(nonzero_byte(), $urandom_range(0, 3) == 0);
                    sent += len + 1;
                end
                7: begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    sent += 1;
                end
                default: begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    sent += 1;
                end
            endcase
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) n_cycles <= n_cycles + 1;

    initial begin
        wait (n_cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats still owed", n_cycles,
                 owed_beats.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_in    = '0;
        clear_encoder();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_literals();
        test_zero_cases();
        test_long_runs();
        test_backpressure();
        test_drain_pause();
        test_random_streams();

        // Let everything owed come out, then a short settle for stray beats.
        push <= 1'b0;
        while (owed_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d bytes in %0d streams, %0d runs closed, %0d beats checked, %0d errors",
                 n_bytes, n_streams, n_runs, n_beats, n_err);
        $display("covered escapes, held zeros, runs up to 20 zeros, tail fills, %0s",
                 "a long output stall and a drained pause");
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
